/* rtl/spectrum_band_to_pwm_top_defines.svh */
// Assertion macros for the top-level file, which checks the block's own logic.
`ifndef SPECTRUM_BAND_TO_PWM_TOP_DEFINES_SVH
`define SPECTRUM_BAND_TO_PWM_TOP_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define SBP_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define SBP_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sbp_pkg.sv */
package sbp_pkg;

    localparam int BIN_COUNT_DEF     = 512;
    localparam int SUB_LAST_BIN_DEF  = 2;
    localparam int BASS_LAST_BIN_DEF = 5;
    localparam int MID_LAST_BIN_DEF  = 46;

    localparam int MAG_W      = 18;
    localparam int IDX_W      = 9;
    localparam int SUM_W      = 24;
    localparam int DUTY_W     = 8;
    localparam int ALPHA_W    = 16;
    localparam int ROOT_W     = 12;
    localparam int SQRT_STEPS = 12;
    localparam int QUO_W      = 16;
    localparam int CNT_W      = $clog2(QUO_W);
    localparam int MAP_SPAN   = 500;
    localparam int BANDS      = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [2:0] REG_MIN_LEVEL      = 3'd0;
    localparam logic [2:0] REG_MAX_LEVEL_SUB  = 3'd1;
    localparam logic [2:0] REG_MAX_LEVEL_BASS = 3'd2;
    localparam logic [2:0] REG_MAX_LEVEL_MID  = 3'd3;
    localparam logic [2:0] REG_SMOOTHING      = 3'd4;
    localparam logic [2:0] REG_GAIN_SUB       = 3'd5;
    localparam logic [2:0] REG_GAIN_BASS      = 3'd6;
    localparam logic [2:0] REG_GAIN_MID       = 3'd7;

    localparam logic [1:0] BAND_SUB  = 2'd0;
    localparam logic [1:0] BAND_BASS = 2'd1;
    localparam logic [1:0] BAND_MID  = 2'd2;

    localparam logic [DUTY_W-1:0]  MIN_LEVEL_RST      = 8'd10;
    localparam logic [DUTY_W-1:0]  MAX_LEVEL_SUB_RST  = 8'd180;
    localparam logic [DUTY_W-1:0]  MAX_LEVEL_BASS_RST = 8'd160;
    localparam logic [DUTY_W-1:0]  MAX_LEVEL_MID_RST  = 8'd160;
    localparam logic [ALPHA_W-1:0] SMOOTHING_RST      = 16'd6554;
    localparam logic [DUTY_W-1:0]  GAIN_SUB_RST       = 8'd32;
    localparam logic [DUTY_W-1:0]  GAIN_BASS_RST      = 8'd26;
    localparam logic [DUTY_W-1:0]  GAIN_MID_RST       = 8'd8;

    typedef logic [BANDS-1:0][SUM_W-1:0] sums_t;

    typedef struct packed {
        logic [DUTY_W-1:0]             min_level;
        logic [BANDS-1:0][DUTY_W-1:0]  max_level;
        logic [ALPHA_W-1:0]            alpha;
        logic [BANDS-1:0][DUTY_W-1:0]  gain;
    } cfg_t;

endpackage

/* rtl/sbp_cfg.sv */
module sbp_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sbp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sbp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sbp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output sbp_pkg::cfg_t                    cfg
);
    import sbp_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_level           <= MIN_LEVEL_RST;
            cfg_reg.max_level[BAND_SUB]  <= MAX_LEVEL_SUB_RST;
            cfg_reg.max_level[BAND_BASS] <= MAX_LEVEL_BASS_RST;
            cfg_reg.max_level[BAND_MID]  <= MAX_LEVEL_MID_RST;
            cfg_reg.alpha               <= SMOOTHING_RST;
            cfg_reg.gain[BAND_SUB]       <= GAIN_SUB_RST;
            cfg_reg.gain[BAND_BASS]      <= GAIN_BASS_RST;
            cfg_reg.gain[BAND_MID]       <= GAIN_MID_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MIN_LEVEL:      cfg_reg.min_level           <= pwdata[DUTY_W-1:0];
                REG_MAX_LEVEL_SUB:  cfg_reg.max_level[BAND_SUB]  <= pwdata[DUTY_W-1:0];
                REG_MAX_LEVEL_BASS: cfg_reg.max_level[BAND_BASS] <= pwdata[DUTY_W-1:0];
                REG_MAX_LEVEL_MID:  cfg_reg.max_level[BAND_MID]  <= pwdata[DUTY_W-1:0];
                REG_SMOOTHING:      cfg_reg.alpha               <= pwdata[ALPHA_W-1:0];
                REG_GAIN_SUB:       cfg_reg.gain[BAND_SUB]       <= pwdata[DUTY_W-1:0];
                REG_GAIN_BASS:      cfg_reg.gain[BAND_BASS]      <= pwdata[DUTY_W-1:0];
                REG_GAIN_MID:       cfg_reg.gain[BAND_MID]       <= pwdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIN_LEVEL:      prdata = APB_DATA_W'(cfg_reg.min_level);
            REG_MAX_LEVEL_SUB:  prdata = APB_DATA_W'(cfg_reg.max_level[BAND_SUB]);
            REG_MAX_LEVEL_BASS: prdata = APB_DATA_W'(cfg_reg.max_level[BAND_BASS]);
            REG_MAX_LEVEL_MID:  prdata = APB_DATA_W'(cfg_reg.max_level[BAND_MID]);
            REG_SMOOTHING:      prdata = APB_DATA_W'(cfg_reg.alpha);
            REG_GAIN_SUB:       prdata = APB_DATA_W'(cfg_reg.gain[BAND_SUB]);
            REG_GAIN_BASS:      prdata = APB_DATA_W'(cfg_reg.gain[BAND_BASS]);
            REG_GAIN_MID:       prdata = APB_DATA_W'(cfg_reg.gain[BAND_MID]);
            default:            prdata = '0;
        endcase
    end

endmodule

/* rtl/sbp_front.sv */
module sbp_front #(
    parameter int BIN_COUNT     = sbp_pkg::BIN_COUNT_DEF,
    parameter int SUB_LAST_BIN  = sbp_pkg::SUB_LAST_BIN_DEF,
    parameter int BASS_LAST_BIN = sbp_pkg::BASS_LAST_BIN_DEF,
    parameter int MID_LAST_BIN  = sbp_pkg::MID_LAST_BIN_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sbp_pkg::MAG_W-1:0]   s_magnitude,
    input  logic [sbp_pkg::IDX_W-1:0]   s_bin_index,
    output logic                        q_push,
    output sbp_pkg::sums_t              q_sums,
    input  logic                        q_full
);
    import sbp_pkg::*;

    sums_t            sums_reg;
    sums_t            sums_next;
    logic             accept;
    logic             last_bin;
    logic             in_band;
    logic [1:0]       band;
    logic [SUM_W-1:0] base;
    logic [SUM_W:0]   add_sum;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign last_bin = (32'(s_bin_index) == 32'(BIN_COUNT - 1));

    always_comb begin
        band    = BAND_MID;
        in_band = 1'b1;
        if (32'(s_bin_index) <= 32'(SUB_LAST_BIN)) begin
            band = BAND_SUB;
        end else if (32'(s_bin_index) <= 32'(BASS_LAST_BIN)) begin
            band = BAND_BASS;
        end else if (32'(s_bin_index) <= 32'(MID_LAST_BIN)) begin
            band = BAND_MID;
        end else begin
            in_band = 1'b0;
        end

        sums_next = sums_reg;
        if (s_bin_index == '0) begin
            sums_next = '0;
        end
        base    = sums_next[band];
        add_sum = {1'b0, base} + (SUM_W + 1)'(s_magnitude);
        if (in_band) begin
            sums_next[band] = add_sum[SUM_W] ? '1 : add_sum[SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sums_reg <= '0;
        end else if (accept) begin
            sums_reg <= sums_next;
        end
    end

    assign q_push = accept && last_bin;
    assign q_sums = sums_next;

endmodule

/* rtl/sbp_queue.sv */
module sbp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_push,
    input  sbp_pkg::sums_t q_wr_sums,
    output logic           q_full,
    output logic           q_valid,
    input  logic           q_pop,
    output sbp_pkg::sums_t q_rd_sums
);
    import sbp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(QUEUE_DEPTH + 1);

    sums_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W_Q-1:0] count_reg;

    assign q_full    = (count_reg == CNT_W_Q'(QUEUE_DEPTH));
    assign q_valid   = (count_reg != '0);
    assign q_rd_sums = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (q_push) begin
            mem_reg[wr_ptr_reg] <= q_wr_sums;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (q_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (q_push && !q_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (q_pop && !q_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/sbp_back.sv */
module sbp_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sbp_pkg::cfg_t                cfg,
    input  logic                         q_valid,
    input  sbp_pkg::sums_t               q_sums,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sbp_pkg::DUTY_W-1:0]   m_duty_sub,
    output logic [sbp_pkg::DUTY_W-1:0]   m_duty_bass,
    output logic [sbp_pkg::DUTY_W-1:0]   m_duty_mid,
    output logic [sbp_pkg::DUTY_W-1:0]   m_duty_fourth
);
    import sbp_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOAD  = 4'd1;
    localparam logic [3:0] ST_SQRT  = 4'd2;
    localparam logic [3:0] ST_GAIN  = 4'd3;
    localparam logic [3:0] ST_SPAN  = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_CLAMP = 4'd6;
    localparam logic [3:0] ST_SMUL  = 4'd7;
    localparam logic [3:0] ST_SADD  = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    localparam int GPROD_W    = ROOT_W + DUTY_W;
    localparam int X_W        = GPROD_W - 4;
    localparam int PROD_W     = X_W + DUTY_W;
    localparam int MVAL_W     = QUO_W + 2;
    localparam int MULA_W     = ALPHA_W + DUTY_W;
    localparam int INV_W      = ALPHA_W + 1;
    localparam int MULB_W     = INV_W + SUM_W;
    localparam int RCP_SHIFT  = PROD_W + $clog2(MAP_SPAN);
    localparam int RCP_W      = RCP_SHIFT - $clog2(MAP_SPAN) + 1;
    localparam int RCP_PROD_W = PROD_W + RCP_W;
    localparam logic [SUM_W-1:0]  SQRT_START = SUM_W'(1) << (SUM_W - 2);
    localparam logic [RCP_W-1:0]  RCP_MUL    =
        RCP_W'(((64'd1 << RCP_SHIFT) + 64'(MAP_SPAN) - 64'd1) / 64'(MAP_SPAN));
    localparam logic [INV_W-1:0]  ALPHA_ONE  = INV_W'(1) << ALPHA_W;

    logic [3:0]          state_reg;
    logic [1:0]          band_reg;
    sums_t               sums_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SUM_W-1:0]    v_reg;
    logic [SUM_W-1:0]    root_reg;
    logic [SUM_W-1:0]    bit_reg;
    logic [X_W-1:0]      x_reg;
    logic                neg_reg;
    logic [PROD_W-1:0]   rem_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic [DUTY_W-1:0]   p_reg;
    logic [MULA_W-1:0]   mula_reg;
    logic [MULB_W-1:0]   mulb_reg;
    logic [SUM_W-1:0]    smooth_reg [BANDS];
    logic [DUTY_W-1:0]   duty_reg [BANDS];
    logic                m_valid_reg;
    logic [DUTY_W-1:0]   m_duty_reg [BANDS];

    logic [SUM_W-1:0]         trial;
    logic                     sq_ge;
    logic [GPROD_W-1:0]       gprod;
    logic signed [DUTY_W:0]   diff;
    logic [DUTY_W:0]          diff_abs;
    logic [RCP_PROD_W-1:0]    rcp_prod;
    logic signed [MVAL_W-1:0] lo_s;
    logic signed [MVAL_W-1:0] hi_s;
    logic signed [MVAL_W-1:0] q_s;
    logic signed [MVAL_W-1:0] mval;
    logic [DUTY_W-1:0]        p_next;
    logic [INV_W-1:0]         inv_alpha;
    logic [SUM_W+1:0]         s_sum;
    logic                     out_free;

    always_comb begin
        trial     = root_reg + bit_reg;
        sq_ge     = (v_reg >= trial);
        gprod     = root_reg[ROOT_W-1:0] * cfg.gain[band_reg];
        diff      = $signed({1'b0, cfg.max_level[band_reg]}) - $signed({1'b0, cfg.min_level});
        diff_abs  = diff[DUTY_W] ? (~diff + 1'b1) : diff;
        rcp_prod  = RCP_PROD_W'(rem_reg) * RCP_PROD_W'(RCP_MUL);
        lo_s      = $signed(MVAL_W'(cfg.min_level));
        hi_s      = $signed(MVAL_W'(cfg.max_level[band_reg]));
        q_s       = $signed(MVAL_W'(quo_reg));
        mval      = neg_reg ? (lo_s - q_s) : (lo_s + q_s);
        if (mval < lo_s) begin
            p_next = cfg.min_level;
        end else if (mval > hi_s) begin
            p_next = cfg.max_level[band_reg];
        end else begin
            p_next = mval[DUTY_W-1:0];
        end
        inv_alpha = ALPHA_ONE - INV_W'(cfg.alpha);
        s_sum     = (SUM_W + 2)'(mula_reg) + (SUM_W + 2)'(mulb_reg[MULB_W-1:ALPHA_W]);
        out_free  = !m_valid_reg || m_ready;
    end

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            band_reg  <= BAND_SUB;
            for (int i = 0; i < BANDS; i++) begin
                smooth_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        sums_reg  <= q_sums;
                        band_reg  <= BAND_SUB;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    v_reg     <= sums_reg[band_reg];
                    root_reg  <= '0;
                    bit_reg   <= SQRT_START;
                    cnt_reg   <= CNT_W'(SQRT_STEPS - 1);
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (sq_ge) begin
                        v_reg    <= v_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_GAIN;
                    end
                end
                ST_GAIN: begin
                    x_reg     <= gprod[GPROD_W-1:4];
                    state_reg <= ST_SPAN;
                end
                ST_SPAN: begin
                    rem_reg   <= x_reg * diff_abs[DUTY_W-1:0];
                    neg_reg   <= diff[DUTY_W];
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    quo_reg   <= rcp_prod[RCP_SHIFT +: QUO_W];
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    p_reg     <= p_next;
                    state_reg <= ST_SMUL;
                end
                ST_SMUL: begin
                    mula_reg  <= cfg.alpha * p_reg;
                    mulb_reg  <= inv_alpha * smooth_reg[band_reg];
                    state_reg <= ST_SADD;
                end
                ST_SADD: begin
                    smooth_reg[band_reg] <= s_sum[SUM_W-1:0];
                    duty_reg[band_reg]   <= s_sum[SUM_W-1:SUM_W-DUTY_W];
                    if (band_reg == BAND_MID) begin
                        state_reg <= ST_OUT;
                    end else begin
                        band_reg  <= band_reg + 1'b1;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            for (int i = 0; i < BANDS; i++) begin
                m_duty_reg[i] <= duty_reg[i];
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_duty_sub    = m_duty_reg[BAND_SUB];
    assign m_duty_bass   = m_duty_reg[BAND_BASS];
    assign m_duty_mid    = m_duty_reg[BAND_MID];
    assign m_duty_fourth = m_duty_reg[BAND_MID];

endmodule

/* rtl/spectrum_band_to_pwm_top.sv */
// Band-level PWM duty generator fed by a stream of spectral magnitude bins.
// Input channel (s_valid/s_ready): one bin per item, s_magnitude in Q10.8 and
// s_bin_index. Bin 0 clears the band sums; the last bin of a frame closes it.
// Result channel (m_valid/m_ready): one item per frame with four 8-bit duties,
// the fourth a copy of the mid band.
// Configuration: APB-style port, registers at byte addresses 0 to 28, pready
// tied high; write only while no frame is in flight.
// Throughput: one bin per cycle while s_ready is high. The closing bin hands
// its sums to a two-entry queue; a sequencer then finishes the three bands
// one after another through a shared 12-step square root, a gain multiply,
// a reciprocal multiply for the division by 500 and the smoothing multiply.
// Frames may close while the sequencer still works on an earlier one;
// s_ready drops while the queue holds two unfinished frames.
// A stalled receiver holds the result register; the sequencer waits behind it.
// Reset (aresetn low, synchronous) clears sums, smoothed duties, the queue
// and loads the register defaults.
`include "spectrum_band_to_pwm_top_defines.svh"

module spectrum_band_to_pwm_top #(
    parameter int BIN_COUNT     = sbp_pkg::BIN_COUNT_DEF,
    parameter int SUB_LAST_BIN  = sbp_pkg::SUB_LAST_BIN_DEF,
    parameter int BASS_LAST_BIN = sbp_pkg::BASS_LAST_BIN_DEF,
    parameter int MID_LAST_BIN  = sbp_pkg::MID_LAST_BIN_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [sbp_pkg::MAG_W-1:0]        s_magnitude,
    input  logic [sbp_pkg::IDX_W-1:0]        s_bin_index,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sbp_pkg::DUTY_W-1:0]       m_duty_sub,
    output logic [sbp_pkg::DUTY_W-1:0]       m_duty_bass,
    output logic [sbp_pkg::DUTY_W-1:0]       m_duty_mid,
    output logic [sbp_pkg::DUTY_W-1:0]       m_duty_fourth,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sbp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sbp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sbp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import sbp_pkg::*;

    cfg_t  cfg;
    logic  q_push;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    sums_t q_wr_sums;
    sums_t q_rd_sums;

    sbp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sbp_front #(
        .BIN_COUNT     (BIN_COUNT),
        .SUB_LAST_BIN  (SUB_LAST_BIN),
        .BASS_LAST_BIN (BASS_LAST_BIN),
        .MID_LAST_BIN  (MID_LAST_BIN)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_magnitude (s_magnitude),
        .s_bin_index (s_bin_index),
        .q_push      (q_push),
        .q_sums      (q_wr_sums),
        .q_full      (q_full)
    );

    sbp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_push    (q_push),
        .q_wr_sums (q_wr_sums),
        .q_full    (q_full),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_rd_sums (q_rd_sums)
    );

    sbp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_sums        (q_rd_sums),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_duty_sub    (m_duty_sub),
        .m_duty_bass   (m_duty_bass),
        .m_duty_mid    (m_duty_mid),
        .m_duty_fourth (m_duty_fourth)
    );

    `SBP_ASSERT_NOW(a_push_not_full, q_push, !q_full, "frame pushed into a full queue")
    `SBP_ASSERT_NOW(a_pop_has_entry, q_pop, q_valid, "frame popped from an empty queue")
    `SBP_ASSERT_NEXT(a_push_visible, q_push, q_valid, "pushed frame not visible to back end")
    `SBP_ASSERT_NOW(a_fourth_mid, m_valid, m_duty_fourth == m_duty_mid, "fourth duty differs")

endmodule

/* tb/tb.sv */
module tb;
    import sbp_pkg::*;

    localparam logic [IDX_W-1:0] LAST_BIN      = IDX_W'(BIN_COUNT_DEF - 1);
    localparam logic [MAG_W-1:0] MAG_FULL      = '1;
    localparam int               SETTLE_CYCLES = 120;
    localparam int               NUM_REGS      = 8;

    typedef struct packed {
        logic [DUTY_W-1:0] sub;
        logic [DUTY_W-1:0] bass;
        logic [DUTY_W-1:0] mid;
        logic [DUTY_W-1:0] fourth;
    } duty_set_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [MAG_W-1:0]      s_magnitude = '0;
    logic [IDX_W-1:0]      s_bin_index = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [DUTY_W-1:0]     m_duty_sub;
    logic [DUTY_W-1:0]     m_duty_bass;
    logic [DUTY_W-1:0]     m_duty_mid;
    logic [DUTY_W-1:0]     m_duty_fourth;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic [SUM_W-1:0]   band_total   [BANDS];
    logic [SUM_W-1:0]   smooth_level [BANDS];
    logic [DUTY_W-1:0]  lvl_min;
    logic [DUTY_W-1:0]  lvl_top      [BANDS];
    logic [ALPHA_W-1:0] alpha;
    logic [DUTY_W-1:0]  band_gain    [BANDS];

    duty_set_t duty_q[$];

    int errors     = 0;
    int n_items    = 0;
    int n_frames   = 0;
    int n_results  = 0;
    int n_settings = 0;
    bit send_idle  = 1'b1;
    bit recv_idle  = 1'b1;

    spectrum_band_to_pwm_top DUT (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int unsigned floor_root(logic [SUM_W-1:0] v);
        int unsigned r;
        int unsigned t;
        r = 0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [DUTY_W-1:0] finish_band(int band);
        int unsigned       root;
        int unsigned       scaled;
        int                lo;
        int                hi;
        int                mapped;
        int                held;
        longint unsigned   a64;
        longint unsigned   held64;
        longint unsigned   acc;
        root   = floor_root(band_total[band]);
        scaled = (root * band_gain[band]) >> 4;
        lo     = int'(lvl_min);
        hi     = int'(lvl_top[band]);
        mapped = int'(scaled) * (hi - lo) / MAP_SPAN + lo;
        held   = (mapped < lo) ? lo : ((mapped > hi) ? hi : mapped);
        a64    = alpha;
        held64 = held;
        acc    = a64 * (held64 << 16) + (64'd65536 - a64) * smooth_level[band];
        smooth_level[band] = acc[SUM_W+15:16];
        return smooth_level[band][SUM_W-1:16];
    endfunction

    function automatic void predict_bin(logic [MAG_W-1:0] mag, logic [IDX_W-1:0] idx);
        logic [SUM_W:0] grown;
        duty_set_t      want;
        int             band;
        if (idx == 0) begin
            foreach (band_total[b])
                band_total[b] = '0;
        end
        if (idx <= SUB_LAST_BIN_DEF)
            band = BAND_SUB;
        else if (idx <= BASS_LAST_BIN_DEF)
            band = BAND_BASS;
        else if (idx <= MID_LAST_BIN_DEF)
            band = BAND_MID;
        else
            band = -1;
        if (band >= 0) begin
            grown = band_total[band] + mag;
            band_total[band] = grown[SUM_W] ? '1 : grown[SUM_W-1:0];
        end
        if (idx == LAST_BIN) begin
            want.sub    = finish_band(BAND_SUB);
            want.bass   = finish_band(BAND_BASS);
            want.mid    = finish_band(BAND_MID);
            want.fourth = want.mid;
            duty_q.push_back(want);
            n_frames++;
        end
    endfunction

    function automatic void load_defaults();
        lvl_min                  = MIN_LEVEL_RST;
        lvl_top[BAND_SUB]        = MAX_LEVEL_SUB_RST;
        lvl_top[BAND_BASS]       = MAX_LEVEL_BASS_RST;
        lvl_top[BAND_MID]        = MAX_LEVEL_MID_RST;
        alpha                    = SMOOTHING_RST;
        band_gain[BAND_SUB]      = GAIN_SUB_RST;
        band_gain[BAND_BASS]     = GAIN_BASS_RST;
        band_gain[BAND_MID]      = GAIN_MID_RST;
        foreach (band_total[b]) begin
            band_total[b]   = '0;
            smooth_level[b] = '0;
        end
    endfunction

    function automatic logic [ALPHA_W-1:0] reg_value(logic [2:0] idx);
        case (idx)
            REG_MIN_LEVEL:      return lvl_min;
            REG_MAX_LEVEL_SUB:  return lvl_top[BAND_SUB];
            REG_MAX_LEVEL_BASS: return lvl_top[BAND_BASS];
            REG_MAX_LEVEL_MID:  return lvl_top[BAND_MID];
            REG_SMOOTHING:      return alpha;
            REG_GAIN_SUB:       return band_gain[BAND_SUB];
            REG_GAIN_BASS:      return band_gain[BAND_BASS];
            REG_GAIN_MID:       return band_gain[BAND_MID];
            default:            return '0;
        endcase
    endfunction

    function automatic void store_reg(logic [2:0] idx, logic [ALPHA_W-1:0] val);
        case (idx)
            REG_MIN_LEVEL:      lvl_min              = val[DUTY_W-1:0];
            REG_MAX_LEVEL_SUB:  lvl_top[BAND_SUB]    = val[DUTY_W-1:0];
            REG_MAX_LEVEL_BASS: lvl_top[BAND_BASS]   = val[DUTY_W-1:0];
            REG_MAX_LEVEL_MID:  lvl_top[BAND_MID]    = val[DUTY_W-1:0];
            REG_SMOOTHING:      alpha                = val;
            REG_GAIN_SUB:       band_gain[BAND_SUB]  = val[DUTY_W-1:0];
            REG_GAIN_BASS:      band_gain[BAND_BASS] = val[DUTY_W-1:0];
            REG_GAIN_MID:       band_gain[BAND_MID]  = val[DUTY_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [MAG_W-1:0] rand_mag();
        case ($urandom_range(0, 7))
            0:       return MAG_FULL;
            1:       return MAG_W'($urandom_range(0, 255));
            2:       return '0;
            default: return MAG_W'($urandom_range(0, int'(MAG_FULL)));
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] rand_bin();
        if ($urandom_range(0, 9) < 7)
            return IDX_W'($urandom_range(1, MID_LAST_BIN_DEF));
        return IDX_W'($urandom_range(1, int'(LAST_BIN) - 1));
    endfunction

    function automatic logic [ALPHA_W-1:0] pick_level(int unsigned top);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return ALPHA_W'(top);
            default: return ALPHA_W'($urandom_range(0, top));
        endcase
    endfunction

    task automatic send_bin(logic [MAG_W-1:0] mag, logic [IDX_W-1:0] idx);
        int gap;
        gap = send_idle ? $urandom_range(0, 8) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_magnitude <= mag;
        s_bin_index <= idx;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_bin(mag, idx);
        n_items++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (duty_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic read_check(logic [2:0] idx);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(idx) << 2;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (prdata !== APB_DATA_W'(reg_value(idx))) begin
            $display("%0t: register %0d read expected %0d actual %0d",
                     $time, idx, reg_value(idx), prdata);
            errors++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [ALPHA_W-1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << 2;
        pwdata  <= APB_DATA_W'(val);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        store_reg(idx, val);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        read_check(idx);
    endtask

    task automatic set_levels(int unsigned lo, int unsigned top_sub, int unsigned top_bass,
                              int unsigned top_mid, int unsigned smooth, int unsigned g_sub,
                              int unsigned g_bass, int unsigned g_mid);
        write_reg(REG_MIN_LEVEL,      ALPHA_W'(lo));
        write_reg(REG_MAX_LEVEL_SUB,  ALPHA_W'(top_sub));
        write_reg(REG_MAX_LEVEL_BASS, ALPHA_W'(top_bass));
        write_reg(REG_MAX_LEVEL_MID,  ALPHA_W'(top_mid));
        write_reg(REG_SMOOTHING,      ALPHA_W'(smooth));
        write_reg(REG_GAIN_SUB,       ALPHA_W'(g_sub));
        write_reg(REG_GAIN_BASS,      ALPHA_W'(g_bass));
        write_reg(REG_GAIN_MID,       ALPHA_W'(g_mid));
        n_settings++;
    endtask

    task automatic send_short_frame();
        send_bin(rand_mag(), '0);
        send_bin(rand_mag(), IDX_W'(SUB_LAST_BIN_DEF));
        send_bin(rand_mag(), IDX_W'(BASS_LAST_BIN_DEF));
        send_bin(rand_mag(), IDX_W'($urandom_range(BASS_LAST_BIN_DEF + 1, MID_LAST_BIN_DEF)));
        send_bin(rand_mag(), LAST_BIN);
    endtask

    task automatic send_random_frame();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind != 1)
            send_bin(rand_mag(), '0);
        if (kind == 0) begin
            repeat ($urandom_range(1, 6))
                send_bin(rand_mag(), IDX_W'($urandom_range(1, int'(LAST_BIN) - 1)));
        end else begin
            repeat ($urandom_range(0, 12))
                send_bin(rand_mag(), rand_bin());
            send_bin(rand_mag(), LAST_BIN);
        end
    endtask

    task automatic check_field(string name, logic [DUTY_W-1:0] want, logic [DUTY_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        duty_set_t want;
        n_results++;
        if (duty_q.size() == 0) begin
            $display("%0t: result with no frame pending, actual %0d %0d %0d %0d", $time,
                     m_duty_sub, m_duty_bass, m_duty_mid, m_duty_fourth);
            errors++;
        end else begin
            want = duty_q.pop_front();
            check_field("duty_sub",    want.sub,    m_duty_sub);
            check_field("duty_bass",   want.bass,   m_duty_bass);
            check_field("duty_mid",    want.mid,    m_duty_mid);
            check_field("duty_fourth", want.fourth, m_duty_fourth);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready)
            check_result();
    end

    initial begin
        int stall;
        forever begin
            stall = recv_idle ? $urandom_range(0, 8) : 0;
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    task automatic test_register_defaults();
        for (int i = 0; i < NUM_REGS; i++)
            read_check(3'(i));
    endtask

    task automatic test_directed_frames();
        send_bin(MAG_FULL, '0);
        send_bin('0, IDX_W'(SUB_LAST_BIN_DEF));
        send_bin(MAG_FULL, 9'd1);
        send_bin(MAG_FULL, IDX_W'(SUB_LAST_BIN_DEF + 1));
        send_bin(18'd1, IDX_W'(BASS_LAST_BIN_DEF));
        send_bin(MAG_FULL, IDX_W'(BASS_LAST_BIN_DEF + 1));
        send_bin(MAG_FULL, IDX_W'(MID_LAST_BIN_DEF));
        send_bin(MAG_FULL, IDX_W'(MID_LAST_BIN_DEF + 1));
        send_bin(rand_mag(), 9'd300);
        send_bin(MAG_FULL, LAST_BIN - 1'b1);
        send_bin(MAG_FULL, LAST_BIN);
        // no start bin: sums carry over from the previous frame
        send_bin(18'h2AAAA, 9'd1);
        send_bin(18'h15555, 9'd4);
        send_bin(rand_mag(), IDX_W'(MID_LAST_BIN_DEF - 1));
        send_bin(rand_mag(), LAST_BIN);
        send_bin('0, '0);
        send_bin(MAG_FULL, LAST_BIN);
        drain();
    endtask

    task automatic test_config_extremes();
        set_levels(0, 255, 255, 255, 65535, 255, 255, 255);
        send_short_frame();
        drain();
        // max below min
        set_levels(255, 0, 0, 0, 65535, 128, 128, 128);
        send_short_frame();
        drain();
        set_levels(200, 100, 150, 250, 40000, 64, 64, 64);
        send_short_frame();
        drain();
        // zero smoothing: duties hold
        set_levels(10, 180, 160, 160, 0, 32, 26, 8);
        send_short_frame();
        drain();
        set_levels(0, 255, 255, 255, 1, 0, 0, 0);
        send_short_frame();
        drain();
    endtask

    task automatic test_sum_saturation();
        set_levels(0, 255, 255, 255, 65535, 16, 16, 16);
        send_bin(MAG_FULL, '0);
        repeat (66) send_bin(MAG_FULL, IDX_W'($urandom_range(1, SUB_LAST_BIN_DEF)));
        repeat (66)
            send_bin(MAG_FULL, IDX_W'($urandom_range(BASS_LAST_BIN_DEF + 1, MID_LAST_BIN_DEF)));
        send_bin(MAG_FULL, LAST_BIN);
        drain();
    endtask

    task automatic test_random_frames();
        int items_at;
        int frames_at;
        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0)
                set_levels(pick_level(255), pick_level(255), pick_level(255), pick_level(255),
                           pick_level(65535), pick_level(255), pick_level(255),
                           pick_level(255));
            send_idle = (phase % 3 != 0);
            recv_idle = (phase % 3 != 1);
            items_at  = n_items;
            frames_at = n_frames;
            while (n_items - items_at < 60 || n_frames - frames_at < 7)
                send_random_frame();
            drain();
        end
    endtask

    initial begin
        load_defaults();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_register_defaults();
        test_directed_frames();
        test_config_extremes();
        test_sum_saturation();
        test_random_frames();
        $display("Run covered %0d bins, %0d closed frames, %0d results, %0d register settings",
                 n_items, n_frames, n_results, n_settings);
        $display("Cases: band sum saturation, max below min, zero smoothing, open frames");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule
